// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the rtl of the coverage grid
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on the rising edge, off during reset
`define OCCG_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("occg check failed");

// next-cycle implication, checked on the rising edge, off during reset
`define OCCG_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("occg check failed");

`endif

// ===== rtl/core/occg_pkg.sv =====
// shared types, codes and sizes of the overlap cost coverage grid
package occg_pkg;

    // grid geometry and count width
    localparam int GRID_W     = 128;
    localparam int GRID_H     = 128;
    localparam int COUNT_BITS = 8;
    localparam int CELLS      = GRID_W * GRID_H;

    // derived widths
    localparam int AW = $clog2(CELLS);        // cell address
    localparam int XB = $clog2(GRID_W);       // column offset within window
    localparam int YB = $clog2(GRID_H);       // row offset within window
    localparam int WW = $clog2(GRID_W + 1);   // effective window width
    localparam int CW = 14;                   // signed map coordinate math

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic signed [CW-1:0]  ONE_S     = 1;

    // operation codes
    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_SUB   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_OVF = 2'd1;
    localparam logic [1:0] ST_UNF = 2'd2;

    // configuration register indexes
    localparam int          CFG_IDX_W  = 2;
    localparam int          CFG_DATA_W = 12;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_W = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_H = 2'd3;

    localparam logic [7:0] CLIP_W_RST = 8'd128;
    localparam logic [7:0] CLIP_H_RST = 8'd128;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [11:0] rect_x;
        logic signed [11:0] rect_y;
        logic [7:0]         rect_w;
        logic [7:0]         rect_h;
    } t_in;

    typedef struct packed {
        logic [31:0] total_cost;
        logic [1:0]  status;
    } t_out;

    typedef struct packed {
        logic signed [11:0] clip_x;
        logic signed [11:0] clip_y;
        logic [7:0]         clip_w;
        logic [7:0]         clip_h;
    } t_cfg;

    // command from the setup pipeline to the grid walker
    typedef struct packed {
        logic          go;
        logic [1:0]    kind;    // op code, OP_NONE when nothing is covered
        logic [AW-1:0] base;    // address of the first covered cell
        logic [XB-1:0] ncols;   // covered columns minus one
        logic [YB-1:0] nrows;   // covered rows minus one
        logic [WW-1:0] stride;  // effective window width
    } t_walk_cmd;

    // status from the grid walker
    typedef struct packed {
        logic        idle;
        logic        done;
        logic [1:0]  status;
        logic [31:0] cost;
    } t_grid_stat;

endpackage

// ===== rtl/core/occg_setup.sv =====
// clip and start-address pipeline: turns one beat into a walk command
module occg_setup (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_go,
    input  occg_pkg::t_in      i_item,
    input  occg_pkg::t_cfg     i_cfg,
    output occg_pkg::t_walk_cmd o_cmd
);

    localparam int CW = occg_pkg::CW;
    localparam int PW = occg_pkg::YB + occg_pkg::WW;

    // stage 1: window and clipped corners
    logic signed [CW-1:0] c_cx, c_cy, c_rx, c_ry, c_rw, c_rh, c_cw, c_ch;
    logic signed [CW-1:0] c_weff, c_heff, c_rx1, c_ry1, c_cx1, c_cy1;
    logic signed [CW-1:0] c_gw, c_gh;

    logic                 r_s1_go;
    logic [1:0]           r_s1_op;
    logic signed [CW-1:0] r_x0, r_y0, r_x1, r_y1, r_cx, r_cy, r_weff;

    // stage 2: window offsets and extents
    logic signed [CW-1:0] c_ox, c_oy, c_nc, c_nr;

    logic                       r_s2_go;
    logic [1:0]                 r_s2_op;
    logic [occg_pkg::XB-1:0]    r_ox, r_ncols;
    logic [occg_pkg::YB-1:0]    r_oy, r_nrows;
    logic [occg_pkg::WW-1:0]    r_stride;

    // stage 3: first cell address
    logic [PW-1:0]              c_prod;
    occg_pkg::t_walk_cmd        r_cmd;

    always_comb begin
        c_gw   = $signed(CW'(occg_pkg::GRID_W));
        c_gh   = $signed(CW'(occg_pkg::GRID_H));
        c_cx   = CW'(i_cfg.clip_x);
        c_cy   = CW'(i_cfg.clip_y);
        c_rx   = CW'(i_item.rect_x);
        c_ry   = CW'(i_item.rect_y);
        c_rw   = $signed(CW'(i_item.rect_w));
        c_rh   = $signed(CW'(i_item.rect_h));
        c_cw   = $signed(CW'(i_cfg.clip_w));
        c_ch   = $signed(CW'(i_cfg.clip_h));
        c_weff = (c_cw > c_gw) ? c_gw : c_cw;
        c_heff = (c_ch > c_gh) ? c_gh : c_ch;
        c_rx1  = c_rx + c_rw - occg_pkg::ONE_S;
        c_ry1  = c_ry + c_rh - occg_pkg::ONE_S;
        c_cx1  = c_cx + c_weff - occg_pkg::ONE_S;
        c_cy1  = c_cy + c_heff - occg_pkg::ONE_S;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_go <= 1'b0;
        end else begin
            r_s1_go <= i_go;
        end
        r_s1_op <= i_item.op;
        r_x0    <= (c_rx > c_cx) ? c_rx : c_cx;
        r_y0    <= (c_ry > c_cy) ? c_ry : c_cy;
        r_x1    <= (c_rx1 < c_cx1) ? c_rx1 : c_cx1;
        r_y1    <= (c_ry1 < c_cy1) ? c_ry1 : c_cy1;
        r_cx    <= c_cx;
        r_cy    <= c_cy;
        r_weff  <= c_weff;
    end

    always_comb begin
        c_ox = r_x0 - r_cx;
        c_oy = r_y0 - r_cy;
        c_nc = r_x1 - r_x0;
        c_nr = r_y1 - r_y0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_go <= 1'b0;
        end else begin
            r_s2_go <= r_s1_go;
        end
        // empty rectangle, empty window or no overlap: nothing to walk
        if ((r_s1_op == occg_pkg::OP_ADD || r_s1_op == occg_pkg::OP_SUB)
                && ((r_x0 > r_x1) || (r_y0 > r_y1))) begin
            r_s2_op <= occg_pkg::OP_NONE;
        end else begin
            r_s2_op <= r_s1_op;
        end
        r_ox     <= c_ox[occg_pkg::XB-1:0];
        r_oy     <= c_oy[occg_pkg::YB-1:0];
        r_ncols  <= c_nc[occg_pkg::XB-1:0];
        r_nrows  <= c_nr[occg_pkg::YB-1:0];
        r_stride <= r_weff[occg_pkg::WW-1:0];
    end

    assign c_prod = PW'(r_oy) * PW'(r_stride);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd.go <= 1'b0;
        end else begin
            r_cmd.go <= r_s2_go;
        end
        r_cmd.kind   <= r_s2_op;
        r_cmd.base   <= occg_pkg::AW'(c_prod) + occg_pkg::AW'(r_ox);
        r_cmd.ncols  <= r_ncols;
        r_cmd.nrows  <= r_nrows;
        r_cmd.stride <= r_stride;
    end

    assign o_cmd = r_cmd;

endmodule

// ===== rtl/core/occg_grid.sv =====
// count memory with read-modify-write walker, clearing pass and cost register
module occg_grid (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  occg_pkg::t_walk_cmd  i_cmd,
    output occg_pkg::t_grid_stat o_stat
);

    localparam int AW = occg_pkg::AW;
    localparam int CB = occg_pkg::COUNT_BITS;

    localparam logic [1:0] W_IDLE  = 2'd0;
    localparam logic [1:0] W_CLR   = 2'd1;
    localparam logic [1:0] W_RUN   = 2'd2;
    localparam logic [1:0] W_DRAIN = 2'd3;

    logic [CB-1:0] r_mem [occg_pkg::CELLS];
    logic [CB-1:0] r_rd;

    logic [1:0]              r_state, n_state;
    logic [AW-1:0]           r_addr, n_addr, r_row, n_row, r_b_addr;
    logic [occg_pkg::XB-1:0] r_col, n_col, r_ncols, n_ncols;
    logic [occg_pkg::YB-1:0] r_rows, n_rows, r_nrows, n_nrows;
    logic [occg_pkg::WW-1:0] r_stride, n_stride;
    logic                    r_add, n_add, r_b_valid, r_done, n_done;
    logic [31:0]             r_cost, n_cost;
    logic [1:0]              r_status, n_status;

    logic          c_we;
    logic [AW-1:0] c_wa;
    logic [CB-1:0] c_wd, c_inc, c_dec;

    always_comb begin
        n_state  = r_state;
        n_addr   = r_addr;
        n_row    = r_row;
        n_col    = r_col;
        n_rows   = r_rows;
        n_ncols  = r_ncols;
        n_nrows  = r_nrows;
        n_stride = r_stride;
        n_add    = r_add;
        n_done   = 1'b0;
        n_cost   = r_cost;
        n_status = r_status;
        c_inc    = r_rd + CB'(1);
        c_dec    = r_rd - CB'(1);
        c_we     = 1'b0;
        c_wa     = r_b_addr;
        c_wd     = '0;

        // modify and write back the cell read last cycle
        if (r_b_valid) begin
            if (r_add) begin
                if (r_rd == occg_pkg::COUNT_MAX) begin
                    n_status = occg_pkg::ST_OVF;
                end else begin
                    c_we = 1'b1;
                    c_wd = c_inc;
                    if (r_rd != '0) begin
                        n_cost = r_cost + 32'(c_inc);
                    end
                end
            end else begin
                if (r_rd == '0) begin
                    n_status = occg_pkg::ST_UNF;
                end else begin
                    c_we = 1'b1;
                    c_wd = c_dec;
                    if (r_rd != CB'(1)) begin
                        n_cost = r_cost - 32'(r_rd);
                    end
                end
            end
        end

        case (r_state)
            W_CLR: begin
                c_we = 1'b1;
                c_wa = r_addr;
                c_wd = '0;
                if (r_addr == AW'(occg_pkg::CELLS - 1)) begin
                    n_state = W_IDLE;
                    n_done  = 1'b1;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            W_IDLE: begin
                if (i_cmd.go) begin
                    n_status = occg_pkg::ST_OK;
                    case (i_cmd.kind)
                        occg_pkg::OP_ADD, occg_pkg::OP_SUB: begin
                            n_addr   = i_cmd.base;
                            n_row    = i_cmd.base;
                            n_col    = '0;
                            n_rows   = '0;
                            n_ncols  = i_cmd.ncols;
                            n_nrows  = i_cmd.nrows;
                            n_stride = i_cmd.stride;
                            n_add    = (i_cmd.kind == occg_pkg::OP_ADD);
                            n_state  = W_RUN;
                        end
                        occg_pkg::OP_CLEAR: begin
                            n_cost  = '0;
                            n_addr  = '0;
                            n_state = W_CLR;
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            W_RUN: begin
                if (r_col == r_ncols) begin
                    if (r_rows == r_nrows) begin
                        n_state = W_DRAIN;
                    end else begin
                        n_row  = r_row + AW'(r_stride);
                        n_addr = r_row + AW'(r_stride);
                        n_col  = '0;
                        n_rows = r_rows + occg_pkg::YB'(1);
                    end
                end else begin
                    n_addr = r_addr + AW'(1);
                    n_col  = r_col + occg_pkg::XB'(1);
                end
            end
            W_DRAIN: begin
                n_state = W_IDLE;
                n_done  = 1'b1;
            end
            default: begin
                n_state = W_IDLE;
            end
        endcase
    end

    // count memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (c_we) begin
            r_mem[c_wa] <= c_wd;
        end
        r_rd <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= W_CLR;
            r_addr    <= '0;
            r_b_valid <= 1'b0;
            r_done    <= 1'b0;
            r_cost    <= '0;
            r_status  <= occg_pkg::ST_OK;
        end else begin
            r_state   <= n_state;
            r_addr    <= n_addr;
            r_b_valid <= (r_state == W_RUN);
            r_done    <= n_done;
            r_cost    <= n_cost;
            r_status  <= n_status;
        end
        r_row    <= n_row;
        r_col    <= n_col;
        r_rows   <= n_rows;
        r_ncols  <= n_ncols;
        r_nrows  <= n_nrows;
        r_stride <= n_stride;
        r_add    <= n_add;
        r_b_addr <= r_addr;
    end

    assign o_stat.idle   = (r_state == W_IDLE);
    assign o_stat.done   = r_done;
    assign o_stat.status = r_status;
    assign o_stat.cost   = r_cost;

endmodule

// ===== rtl/core/overlap_cost_coverage_grid.sv =====
// top level of the overlap cost coverage grid: handshakes, clip registers, result register
// flow: three setup stages, walk over the covered cells, drain, result register; a clear
// walks all GRID_W*GRID_H cells, and with nothing covered or an unused op there is no walk
// throughput: one item at a time; the next input beat is taken once the result is registered
// reset: synchronous, active low; then a clearing pass over the GRID_W*GRID_H (16384) cells
// with input stalled; clip writes are taken throughout
`include "assert_macros.svh"

module overlap_cost_coverage_grid (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  occg_pkg::t_in                        i_in,
    // result channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output occg_pkg::t_out                       o_out,
    // clip register write channel
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [occg_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [occg_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    // item sequencer states
    localparam logic [1:0] T_IDLE = 2'd0;   // waiting for an input beat
    localparam logic [1:0] T_RUN  = 2'd1;   // setup pipeline and grid walk in flight
    localparam logic [1:0] T_DONE = 2'd2;   // result ready, waiting for a free output slot

    logic [1:0]           r_state, n_state;
    occg_pkg::t_cfg       r_cfg;
    occg_pkg::t_out       r_out;
    logic                 r_out_valid;

    occg_pkg::t_walk_cmd  w_cmd;
    occg_pkg::t_grid_stat w_stat;

    logic c_in_acc;
    logic c_out_free;

    // a beat enters only when the sequencer and the walker are both idle;
    // the walker is busy right after reset while its clearing pass runs
    assign o_in_stall = !(r_state == T_IDLE && w_stat.idle);
    assign c_in_acc   = i_in_valid && !o_in_stall;

    // output slot can take a new result when empty or when its beat leaves now
    assign c_out_free = !r_out_valid || !i_out_stall;

    // clip writes always land; the user must make them only while idle, unenforced here
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.clip_x <= '0;
            r_cfg.clip_y <= '0;
            r_cfg.clip_w <= occg_pkg::CLIP_W_RST;
            r_cfg.clip_h <= occg_pkg::CLIP_H_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_idx)
                occg_pkg::CFG_CLIP_X: r_cfg.clip_x <= i_cfg_data;
                occg_pkg::CFG_CLIP_Y: r_cfg.clip_y <= i_cfg_data;
                occg_pkg::CFG_CLIP_W: r_cfg.clip_w <= i_cfg_data[7:0];
                occg_pkg::CFG_CLIP_H: r_cfg.clip_h <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // clipping and first cell address, three register stages
    occg_setup u_setup (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (c_in_acc),
        .i_item  (i_in),
        .i_cfg   (r_cfg),
        .o_cmd   (w_cmd)
    );

    // count memory, read-modify-write walk and running cost
    occg_grid u_grid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            T_IDLE: begin
                if (c_in_acc) begin
                    n_state = T_RUN;
                end
            end
            T_RUN: begin
                // done pulse comes in the cycle after the last write-back
                if (w_stat.done) begin
                    n_state = T_DONE;
                end
            end
            T_DONE: begin
                if (c_out_free) begin
                    n_state = T_IDLE;
                end
            end
            default: begin
                n_state = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= T_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == T_DONE && c_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        // cost and status stay put in the walker until the next command
        if (r_state == T_DONE && c_out_free) begin
            r_out.total_cost <= w_stat.cost;
            r_out.status     <= w_stat.status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // an accepted beat keeps the input stalled on the next cycle
    `OCCG_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, c_in_acc, o_in_stall)
    // walker completions arrive only for an item in flight or for the reset clear
    `OCCG_ASSERT_IMP(a_done_when_expected, i_clk, i_rst_n, w_stat.done, r_state == T_RUN || r_state == T_IDLE)
    // a new result appears only out of the done state
    `OCCG_ASSERT_IMP(a_result_from_done, i_clk, i_rst_n, $rose(o_out_valid), $past(r_state) == T_DONE)
    // no walker command while the walker is busy
    `OCCG_ASSERT_IMP(a_cmd_when_idle, i_clk, i_rst_n, w_cmd.go, w_stat.idle)

endmodule

// ===== sim/tb_overlap_cost_coverage_grid.sv =====
// testbench of the overlap cost coverage grid: random rectangles and clip settings checked beat by beat
`timescale 1ns / 100ps

module tb_overlap_cost_coverage_grid;
    import occg_pkg::*;

    // keeps a shadow of the grid and the running cost, and the costs still to come out
    class grid_cost_board;
        bit [COUNT_BITS-1:0] counts [CELLS];
        bit [31:0]           cost;
        t_cfg                clip;
        t_out                pending_costs [$];
        int                  fails;
        int                  items;
        int                  results;
        int                  clears;
        int                  ovf_holds;
        int                  unf_holds;

        function new();
            clip.clip_x = '0;
            clip.clip_y = '0;
            clip.clip_w = CLIP_W_RST;
            clip.clip_h = CLIP_H_RST;
            cost        = '0;
        endfunction

        function int win_w();
            return (clip.clip_w > GRID_W) ? GRID_W : int'(clip.clip_w);
        endfunction

        function int win_h();
            return (clip.clip_h > GRID_H) ? GRID_H : int'(clip.clip_h);
        endfunction

        function void set_clip(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_CLIP_X: clip.clip_x = data;
                CFG_CLIP_Y: clip.clip_y = data;
                CFG_CLIP_W: clip.clip_w = data[7:0];
                CFG_CLIP_H: clip.clip_h = data[7:0];
                default: ;
            endcase
        endfunction

        // clip the rectangle to the window and bump every covered cell
        function bit [1:0] walk_rect(bit add, t_in it);
            int ww, wh, cx, cy, rx, ry, rw, rh, x0, y0, x1, y1, idx;
            bit [COUNT_BITS-1:0] c;
            bit [1:0] st;
            st = ST_OK;
            ww = win_w();
            wh = win_h();
            cx = $signed(clip.clip_x);
            cy = $signed(clip.clip_y);
            rx = $signed(it.rect_x);
            ry = $signed(it.rect_y);
            rw = it.rect_w;
            rh = it.rect_h;
            if (ww == 0 || wh == 0 || rw == 0 || rh == 0)
                return ST_OK;
            x0 = (rx > cx) ? rx : cx;
            y0 = (ry > cy) ? ry : cy;
            x1 = (rx + rw - 1 < cx + ww - 1) ? rx + rw - 1 : cx + ww - 1;
            y1 = (ry + rh - 1 < cy + wh - 1) ? ry + rh - 1 : cy + wh - 1;
            if (x0 > x1 || y0 > y1)
                return ST_OK;
            for (int y = y0 - cy; y <= y1 - cy; y++) begin
                for (int x = x0 - cx; x <= x1 - cx; x++) begin
                    idx = y * ww + x;
                    if (idx >= CELLS)
                        continue;
                    c = counts[idx];
                    if (add) begin
                        if (c == COUNT_MAX) begin
                            st = ST_OVF;
                            continue;
                        end
                        c = c + 1'b1;
                        counts[idx] = c;
                        if (c != 1)
                            cost = cost + 32'(c);
                    end else begin
                        if (c == 0) begin
                            st = ST_UNF;
                            continue;
                        end
                        counts[idx] = c - 1'b1;
                        if (c != 1)
                            cost = cost - 32'(c);
                    end
                end
            end
            return st;
        endfunction

        function void take_item(t_in it);
            t_out want;
            want.status = ST_OK;
            case (it.op)
                OP_ADD: want.status = walk_rect(1'b1, it);
                OP_SUB: want.status = walk_rect(1'b0, it);
                OP_CLEAR: begin
                    foreach (counts[i])
                        counts[i] = '0;
                    cost = '0;
                    clears++;
                end
                default: ;
            endcase
            if (want.status == ST_OVF)
                ovf_holds++;
            if (want.status == ST_UNF)
                unf_holds++;
            want.total_cost = cost;
            pending_costs.push_back(want);
            items++;
        endfunction

        function void check_result(t_out got);
            t_out want;
            results++;
            if (pending_costs.size() == 0) begin
                $error("result beat with nothing pending: total_cost %0d status %0d",
                       got.total_cost, got.status);
                fails++;
                return;
            end
            want = pending_costs.pop_front();
            if (got.total_cost !== want.total_cost) begin
                $error("total_cost: expected %0d, actual %0d", want.total_cost, got.total_cost);
                fails++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                fails++;
            end
        endfunction
    endclass

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    t_in                   i_in        = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out                  o_out;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    grid_cost_board board;
    int             tx_quiet    = 0;   // beats left in a no-gap stretch, sender side
    int             rx_quiet    = 0;   // same for the result side
    int             clears_left = 10;  // each clear walks the whole grid, keep them rare
    int             bigs_left   = 12;  // same for rectangles that may cover the whole window
    t_in            recent_adds [$];   // recently added rectangles, taken off again later

    always #6 i_clk = ~i_clk;

    overlap_cost_coverage_grid DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    // wait before a beat, drawn at random, with runs of back-to-back beats now and then
    function automatic int idle_draw(inout int quiet);
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            quiet = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 9);
    endfunction

    function automatic logic signed [11:0] clamp12(int v);
        if (v < -2048)
            return 12'sh800;
        if (v > 2047)
            return 12'sh7ff;
        return 12'(v);
    endfunction

    function automatic t_in mk(logic [1:0] op, int x, int y, int w, int h);
        t_in it;
        it.op     = op;
        it.rect_x = 12'(x);
        it.rect_y = 12'(y);
        it.rect_w = 8'(w);
        it.rect_h = 8'(h);
        return it;
    endfunction

    // rectangle placed around the current clip window, sides up to the given size
    function automatic t_in near_rect(logic [1:0] op, int side);
        t_in it;
        int  ww, wh, ox, oy;
        ww = (board.win_w() == 0) ? 1 : board.win_w();
        wh = (board.win_h() == 0) ? 1 : board.win_h();
        ox = $urandom_range(0, ww + 2 * side);
        oy = $urandom_range(0, wh + 2 * side);
        it.op     = op;
        it.rect_x = clamp12(int'($signed(board.clip.clip_x)) + ox - side);
        it.rect_y = clamp12(int'($signed(board.clip.clip_y)) + oy - side);
        it.rect_w = 8'($urandom_range(0, side));
        it.rect_h = 8'($urandom_range(0, side));
        return it;
    endfunction

    // one input beat: optional gap, then hold valid until the block takes it
    task automatic send_item(t_in it);
        int w;
        w = idle_draw(tx_quiet);
        if (w > 0) begin
            i_in_valid <= 1'b0;
            repeat (w) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.take_item(it);
    endtask

    // clip register write; the caller drops valid after the last one
    task automatic write_clip(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        board.set_clip(idx, data);
    endtask

    // stop sending and let every pending result drain
    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (board.pending_costs.size() != 0);
    endtask

    // mostly well-formed add/remove traffic near the window, some noise and clears
    task automatic run_mix(int n);
        t_in it;
        int  pick;
        repeat (n) begin
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                // raw noise over the full field ranges
                it.op     = 2'($urandom_range(0, 3));
                it.rect_x = 12'($urandom);
                it.rect_y = 12'($urandom);
                it.rect_w = 8'($urandom);
                it.rect_h = 8'($urandom);
            end else if (pick < 7 && clears_left > 0) begin
                clears_left--;
                it = near_rect(OP_CLEAR, 8);
            end else if (pick < 9) begin
                it = near_rect(OP_NONE, 8);
            end else if (pick < 12 && bigs_left > 0) begin
                bigs_left--;
                it = near_rect(($urandom_range(0, 1) == 0) ? OP_ADD : OP_SUB, 255);
            end else if (pick < 45 && recent_adds.size() > 0) begin
                // take back an earlier add
                it    = recent_adds[$urandom_range(0, recent_adds.size() - 1)];
                it.op = OP_SUB;
            end else begin
                it = near_rect(($urandom_range(0, 5) == 0) ? OP_SUB : OP_ADD, 12);
                if (it.op == OP_ADD) begin
                    recent_adds.push_back(it);
                    if (recent_adds.size() > 16)
                        void'(recent_adds.pop_front());
                end
            end
            send_item(it);
        end
    endtask

    // result side: random stalls per beat, every accepted beat goes to the scoreboard
    initial begin
        int w;
        wait (i_rst_n === 1'b1);
        forever begin
            w = idle_draw(rx_quiet);
            if (w > 0) begin
                i_out_stall <= 1'b1;
                repeat (w) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            board.check_result(o_out);
        end
    end

    // hard stop: generous against the slowest legal run (clears and full-window walks)
    initial begin
        #50_000_000;
        $display("[overlap_cost_coverage_grid] ERROR");
        $finish;
    end

    initial begin
        t_in hot;
        t_in it;
        int  reps;
        int  ww;
        int  wh;
        board = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed beats on the reset window (0,0) 128x128; input stays stalled
        // during the clearing pass after reset
        send_item(mk(OP_ADD, 0, 0, 1, 1));              // first cover of a cell, no cost
        send_item(mk(OP_ADD, 0, 0, 1, 1));              // second cover adds 2
        send_item(mk(OP_ADD, -2048, -2048, 255, 255));  // far corner, misses the window
        send_item(mk(OP_ADD, 2047, 2047, 255, 255));    // other far corner, misses
        send_item(mk(OP_ADD, 127, 127, 255, 255));      // only the last cell survives clipping
        send_item(mk(OP_ADD, -5, -5, 10, 10));          // clipped on the left and top
        send_item(mk(OP_ADD, 3, 3, 0, 7));              // empty width
        send_item(mk(OP_ADD, 3, 3, 7, 0));              // empty height
        send_item(mk(OP_SUB, 0, 0, 2, 2));              // mixed counts under one subtract
        send_item(mk(OP_SUB, 100, 100, 1, 1));          // subtract from zero is held
        send_item(mk(OP_NONE, -1, -1, 255, 255));       // unused op code
        send_item(mk(OP_ADD, -2048, 5, 255, 3));        // far edge still left of the window
        send_item(mk(OP_ADD, 0, 0, 255, 255));          // whole window
        send_item(mk(OP_SUB, -1, -1, 255, 255));        // whole window back off
        send_item(mk(OP_SUB, 127, 127, 1, 1));
        send_item(mk(OP_CLEAR, 2047, -2048, 255, 0));   // clear with odd fields
        send_item(mk(OP_ADD, 64, 64, 3, 3));
        send_item(mk(OP_ADD, 65, 65, 3, 3));            // overlap of two 3x3 labels
        send_item(mk(OP_SUB, 2047, -2048, 0, 255));     // empty subtract

        for (int phase = 1; phase <= 6; phase++) begin
            settle();
            // sometimes start clean; phase 5 keeps the counts to exercise the new stride
            if (phase != 5 && $urandom_range(0, 1) == 1) begin
                send_item(mk(OP_CLEAR, $urandom, $urandom, $urandom, $urandom));
                settle();
            end
            case (phase)
                1: begin
                    // smallest window at the most negative corner
                    write_clip(CFG_CLIP_X, 12'h800);
                    write_clip(CFG_CLIP_Y, 12'h800);
                    write_clip(CFG_CLIP_W, 12'd1);
                    write_clip(CFG_CLIP_H, 12'd1);
                end
                2: begin
                    // most positive corner, sizes above the grid; upper data bits ignored
                    write_clip(CFG_CLIP_X, 12'h7ff);
                    write_clip(CFG_CLIP_Y, 12'h7ff);
                    write_clip(CFG_CLIP_W, {4'($urandom), 8'd255});
                    write_clip(CFG_CLIP_H, {4'($urandom), 8'd129});
                end
                3: begin
                    // zero width: nothing can be covered
                    write_clip(CFG_CLIP_X, 12'd0);
                    write_clip(CFG_CLIP_Y, 12'($urandom));
                    write_clip(CFG_CLIP_W, 12'd0);
                    write_clip(CFG_CLIP_H, 12'd200);
                end
                4: begin
                    write_clip(CFG_CLIP_X, 12'($urandom_range(0, 600) - 300));
                    write_clip(CFG_CLIP_Y, 12'($urandom_range(0, 600) - 300));
                    write_clip(CFG_CLIP_W, 12'($urandom_range(1, 128)));
                    write_clip(CFG_CLIP_H, 12'($urandom_range(1, 128)));
                end
                5: begin
                    // new stride over the old counts
                    write_clip(CFG_CLIP_W, {4'($urandom), 8'($urandom_range(1, 128))});
                end
                default: begin
                    write_clip(CFG_CLIP_X, 12'($urandom));
                    write_clip(CFG_CLIP_Y, 12'($urandom));
                    write_clip(CFG_CLIP_W, 12'($urandom));
                    write_clip(CFG_CLIP_H, 12'($urandom));
                end
            endcase
            i_cfg_valid <= 1'b0;
            recent_adds.delete();

            run_mix((phase == 3) ? 30 : 115);

            if (phase == 4) begin
                // pile one small label on a hot spot past the count limit, then strip it
                // below zero; a few neighbors with the same op are mixed in
                ww = board.win_w();
                wh = board.win_h();
                hot = mk(OP_ADD,
                         int'($signed(board.clip.clip_x)) + $urandom_range(0, ww - 1),
                         int'($signed(board.clip.clip_y)) + $urandom_range(0, wh - 1),
                         $urandom_range(1, 3), $urandom_range(1, 3));
                reps = 256 + $urandom_range(0, 6);
                for (int pass = 0; pass < 2; pass++) begin
                    hot.op = (pass == 0) ? OP_ADD : OP_SUB;
                    repeat (reps + pass * 20) begin
                        if ($urandom_range(0, 9) == 0)
                            it = near_rect(hot.op, 6);
                        else
                            it = hot;
                        send_item(it);
                    end
                end
            end
        end

        settle();
        repeat (40) @(posedge i_clk);
        if (board.pending_costs.size() != 0) begin
            $error("%0d results never arrived", board.pending_costs.size());
            board.fails++;
        end

        $display("run: %0d input beats over 7 clip windows, %0d grid clears",
                 board.items, board.clears);
        $display("run: %0d results checked, %0d with overflow held, %0d with underflow held",
                 board.results, board.ovf_holds, board.unf_holds);
        if (board.fails == 0)
            $display("[overlap_cost_coverage_grid] OK");
        else
            $display("[overlap_cost_coverage_grid] ERROR");
        $finish;
    end

endmodule
